/* rtl/samrx_pkg.sv */
// Shared types, constants and a helper function of the SAM record to read extractor.
package samrx_pkg;

   localparam int MAX_NAME    = 256;
   localparam int MAX_READ    = 4096;
   localparam int SKIP_FIELDS = 7;

   localparam int NAME_AW    = $clog2(MAX_NAME);
   localparam int READ_AW    = $clog2(MAX_READ);
   localparam int NAME_LEN_W = $clog2(MAX_NAME + 1);
   localparam int READ_LEN_W = $clog2(MAX_READ + 1);
   localparam int DRAIN_W    = $clog2(MAX_NAME + 2 * MAX_READ + 1);
   localparam int SKIP_W     = 3;
   localparam int FLAG_W     = 32;
   localparam int REV_BIT    = 4;

   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_NL   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_T    = 8'h54;
   localparam logic [7:0] CHAR_N    = 8'h4E;

   localparam logic [FLAG_W+3:0] FLAG_LIMIT = 36'h0_7FFF_FFFF;

   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_DRAIN = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_ACCEPT     = 4'd0,
      ST_READY      = 4'd1,
      ST_BYTE       = 4'd2,
      ST_EMPTY      = 4'd3,
      ST_BUSY       = 4'd4,
      ST_MALFORMED  = 4'd5,
      ST_MISMATCH   = 4'd6,
      ST_LONG       = 4'd7,
      ST_INCOMPLETE = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      PH_NAME = 3'd0,
      PH_FLAG = 3'd1,
      PH_SKIP = 3'd2,
      PH_SEQ  = 3'd3,
      PH_QUAL = 3'd4,
      PH_LINE = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      SECT_NAME = 2'd0,
      SECT_SEQ  = 2'd1,
      SECT_QUAL = 2'd2
   } sect_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_NAME = 2'd1,
      SRC_BASE = 2'd2,
      SRC_QUAL = 2'd3
   } src_type;

   typedef struct packed {
      status_type             status;
      sect_type               section;
      logic                   last;
      logic [NAME_LEN_W-1:0]  name_length;
      logic [READ_LEN_W-1:0]  read_length;
      src_type                src;
      logic                   comp;
   } rsp_meta_type;

   typedef struct packed {
      logic [3:0]             status;
      logic [7:0]             out_byte;
      logic [1:0]             section;
      logic                   last;
      logic [NAME_LEN_W-1:0]  name_length;
      logic [READ_LEN_W-1:0]  read_length;
   } rsp_type;

   function automatic logic [7:0] complement_base(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CHAR_A:  r = CHAR_T;
         CHAR_C:  r = CHAR_G;
         CHAR_G:  r = CHAR_C;
         CHAR_T:  r = CHAR_A;
         default: r = CHAR_N;
      endcase
      return r;
   endfunction

endpackage

/* rtl/sam_record_to_read_extractor.sv */
// Top level of the SAM record to read extractor: parser, record stores and drain pipeline.
//
//   channel  direction  ports                       one transfer carries
//   req      in         req_valid / req_ready       mode and one text byte
//   rsp      out        rsp_valid / rsp_ready       status, drained byte, section, last flag, lengths
//
// One request per cycle is taken while req_ready is high, then registered in s1_ff and out_ff.
// The limit is the single access of each record store per request.
// Every drain tick that yields a byte reads one store, and the read data is registered before output.
// Synchronous reset clears the parser and the pipeline; the stores keep their contents.
// When the output register is full and not taken, the middle stage holds its transfer
// and the request channel stalls once that stage is occupied too.
module sam_record_to_read_extractor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_status,
   output logic [7:0]                        rsp_out_byte,
   output logic [1:0]                        rsp_section,
   output logic                              rsp_last_of_record,
   output logic [samrx_pkg::NAME_LEN_W-1:0]  rsp_name_length,
   output logic [samrx_pkg::READ_LEN_W-1:0]  rsp_read_length
);

   import samrx_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [SKIP_W-1:0]      skipped_ff, skipped_in;
   logic [FLAG_W-1:0]      flag_ff, flag_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic [NAME_LEN_W-1:0]  name_count_ff, name_count_in;
   logic [READ_LEN_W-1:0]  base_count_ff, base_count_in;
   logic [READ_LEN_W-1:0]  qual_count_ff, qual_count_in;
   logic                   pending_ff, pending_in;
   logic [DRAIN_W-1:0]     drain_pos_ff, drain_pos_in;

   logic                   s1_valid_ff, s1_valid_in;
   rsp_meta_type           s1_ff, meta_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic                   req_fire, s1_adv, s1_move;
   logic                   is_tab, is_nl, is_digit;
   logic [FLAG_W+3:0]      flag_wide;
   logic                   flag_over;
   logic                   name_full, base_full, qual_full, skip_hit, mismatch;
   logic                   clear_rec;

   logic                   name_we, base_we, qual_we;
   logic                   name_re, base_re, qual_re;
   logic [NAME_AW-1:0]     name_raddr;
   logic [READ_AW-1:0]     base_raddr, qual_raddr;
   logic [7:0]             name_rdata, base_rdata, qual_rdata;

   logic [DRAIN_W-1:0]     name_end, seq_end, total, pos_next, seq_i, qual_i;
   logic [DRAIN_W-1:0]     seq_rev, qual_rev;
   logic                   rev;
   logic [7:0]             byte_sel;

   assign s1_adv    = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && s1_adv;

   assign is_tab    = (req_data_byte == CHAR_TAB);
   assign is_nl     = (req_data_byte == CHAR_NL);
   assign is_digit  = (req_data_byte >= CHAR_ZERO) && (req_data_byte <= CHAR_NINE);
   assign flag_wide = ({4'b0, flag_ff} << 3) + ({4'b0, flag_ff} << 1)
                      + (FLAG_W + 4)'(req_data_byte[3:0]);
   assign flag_over = (flag_wide > FLAG_LIMIT);

   assign name_full = (name_count_ff >= NAME_LEN_W'(MAX_NAME));
   assign base_full = (base_count_ff >= READ_LEN_W'(MAX_READ));
   assign qual_full = (qual_count_ff >= READ_LEN_W'(MAX_READ));
   assign skip_hit  = ((skipped_ff + 1'b1) >= SKIP_W'(SKIP_FIELDS));
   assign mismatch  = (qual_count_ff != base_count_ff);

   assign name_end  = DRAIN_W'(name_count_ff);
   assign seq_end   = name_end + DRAIN_W'(base_count_ff);
   assign total     = seq_end + DRAIN_W'(base_count_ff);
   assign pos_next  = drain_pos_ff + 1'b1;
   assign seq_i     = drain_pos_ff - name_end;
   assign qual_i    = drain_pos_ff - seq_end;
   assign seq_rev   = DRAIN_W'(base_count_ff) - 1'b1 - seq_i;
   assign qual_rev  = DRAIN_W'(base_count_ff) - 1'b1 - qual_i;
   assign rev       = flag_ff[REV_BIT];

   assign name_raddr = drain_pos_ff[NAME_AW-1:0];
   assign base_raddr = rev ? seq_rev[READ_AW-1:0] : seq_i[READ_AW-1:0];
   assign qual_raddr = rev ? qual_rev[READ_AW-1:0] : qual_i[READ_AW-1:0];

   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         case (req_mode)
            MODE_BYTE: begin
               case (phase_ff)
                  PH_NAME: begin
                     if (!pending_ff && !is_tab && !is_nl && name_full) begin
                        phase_in = PH_LINE;
                     end else if (!pending_ff && is_tab) begin
                        phase_in = PH_FLAG;
                     end
                  end
                  PH_FLAG: begin
                     if (is_nl) begin
                        phase_in = PH_NAME;
                     end else if (is_tab) begin
                        phase_in = digit_seen_ff ? PH_SKIP : PH_LINE;
                     end else if (!is_digit || flag_over) begin
                        phase_in = PH_LINE;
                     end
                  end
                  PH_SKIP: begin
                     if (is_nl) begin
                        phase_in = PH_NAME;
                     end else if (is_tab && skip_hit) begin
                        phase_in = PH_SEQ;
                     end
                  end
                  PH_SEQ: begin
                     if (is_nl) begin
                        phase_in = PH_NAME;
                     end else if (is_tab) begin
                        phase_in = PH_QUAL;
                     end else if (base_full) begin
                        phase_in = PH_LINE;
                     end
                  end
                  PH_QUAL: begin
                     if (is_nl) begin
                        phase_in = PH_NAME;
                     end else if (is_tab || qual_full) begin
                        phase_in = PH_LINE;
                     end
                  end
                  default: begin
                     if (is_nl) begin
                        phase_in = PH_NAME;
                     end
                  end
               endcase
            end
            MODE_END: begin
               phase_in = PH_NAME;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      skipped_in    = skipped_ff;
      flag_in       = flag_ff;
      digit_seen_in = digit_seen_ff;
      name_count_in = name_count_ff;
      base_count_in = base_count_ff;
      qual_count_in = qual_count_ff;
      pending_in    = pending_ff;
      drain_pos_in  = drain_pos_ff;
      clear_rec     = 1'b0;
      name_we       = 1'b0;
      base_we       = 1'b0;
      qual_we       = 1'b0;
      name_re       = 1'b0;
      base_re       = 1'b0;
      qual_re       = 1'b0;
      meta_in       = '{status: ST_ACCEPT, section: SECT_NAME, last: 1'b0,
                        name_length: '0, read_length: '0, src: SRC_NONE, comp: 1'b0};
      if (req_fire) begin
         case (req_mode)
            MODE_BYTE: begin
               case (phase_ff)
                  PH_NAME: begin
                     if (pending_ff) begin
                        meta_in.status = ST_BUSY;
                     end else if (is_tab) begin
                        flag_in       = '0;
                        digit_seen_in = 1'b0;
                     end else if (is_nl) begin
                        if (name_count_ff != '0) begin
                           meta_in.status = ST_INCOMPLETE;
                           clear_rec      = 1'b1;
                        end
                     end else if (name_full) begin
                        meta_in.status = ST_LONG;
                        clear_rec      = 1'b1;
                     end else begin
                        name_we       = 1'b1;
                        name_count_in = name_count_ff + 1'b1;
                     end
                  end
                  PH_FLAG: begin
                     if (is_nl) begin
                        meta_in.status = ST_INCOMPLETE;
                        clear_rec      = 1'b1;
                     end else if (is_tab) begin
                        if (!digit_seen_ff) begin
                           meta_in.status = ST_MALFORMED;
                           clear_rec      = 1'b1;
                        end else begin
                           skipped_in = '0;
                        end
                     end else if (!is_digit || flag_over) begin
                        meta_in.status = ST_MALFORMED;
                        clear_rec      = 1'b1;
                     end else begin
                        flag_in       = flag_wide[FLAG_W-1:0];
                        digit_seen_in = 1'b1;
                     end
                  end
                  PH_SKIP: begin
                     if (is_nl) begin
                        meta_in.status = ST_INCOMPLETE;
                        clear_rec      = 1'b1;
                     end else if (is_tab) begin
                        skipped_in = skipped_ff + 1'b1;
                     end
                  end
                  PH_SEQ: begin
                     if (is_nl) begin
                        meta_in.status = ST_INCOMPLETE;
                        clear_rec      = 1'b1;
                     end else if (is_tab) begin
                        meta_in.status = ST_ACCEPT;
                     end else if (base_full) begin
                        meta_in.status = ST_LONG;
                        clear_rec      = 1'b1;
                     end else begin
                        base_we       = 1'b1;
                        base_count_in = base_count_ff + 1'b1;
                     end
                  end
                  PH_QUAL: begin
                     if (is_tab || is_nl) begin
                        if (mismatch) begin
                           meta_in.status = ST_MISMATCH;
                           clear_rec      = 1'b1;
                        end else begin
                           meta_in.status      = ST_READY;
                           meta_in.name_length = name_count_ff;
                           meta_in.read_length = base_count_ff;
                           pending_in          = 1'b1;
                           drain_pos_in        = '0;
                        end
                     end else if (qual_full) begin
                        meta_in.status = ST_LONG;
                        clear_rec      = 1'b1;
                     end else begin
                        qual_we       = 1'b1;
                        qual_count_in = qual_count_ff + 1'b1;
                     end
                  end
                  default: begin
                     meta_in.status = ST_ACCEPT;
                  end
               endcase
            end
            MODE_DRAIN: begin
               if (!pending_ff) begin
                  meta_in.status = ST_EMPTY;
               end else if (drain_pos_ff >= total) begin
                  meta_in.status = ST_EMPTY;
                  pending_in     = 1'b0;
                  clear_rec      = 1'b1;
               end else begin
                  meta_in.status = ST_BYTE;
                  drain_pos_in   = pos_next;
                  if (drain_pos_ff < name_end) begin
                     meta_in.section = SECT_NAME;
                     meta_in.src     = SRC_NAME;
                     name_re         = 1'b1;
                  end else if (drain_pos_ff < seq_end) begin
                     meta_in.section = SECT_SEQ;
                     meta_in.src     = SRC_BASE;
                     meta_in.comp    = rev;
                     base_re         = 1'b1;
                  end else begin
                     meta_in.section = SECT_QUAL;
                     meta_in.src     = SRC_QUAL;
                     qual_re         = 1'b1;
                  end
                  if (pos_next == total) begin
                     meta_in.last = 1'b1;
                     pending_in   = 1'b0;
                     clear_rec    = 1'b1;
                  end
               end
            end
            MODE_END: begin
               if (!pending_ff && phase_ff != PH_LINE &&
                   (phase_ff != PH_NAME || name_count_ff != '0)) begin
                  meta_in.status = ST_INCOMPLETE;
                  clear_rec      = 1'b1;
               end
            end
            default: begin
               meta_in.status = ST_ACCEPT;
            end
         endcase
      end
      if (clear_rec) begin
         name_count_in = '0;
         base_count_in = '0;
         qual_count_in = '0;
         drain_pos_in  = '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      case (s1_ff.src)
         SRC_NAME: byte_sel = name_rdata;
         SRC_BASE: byte_sel = s1_ff.comp ? complement_base(base_rdata) : base_rdata;
         SRC_QUAL: byte_sel = qual_rdata;
         default:  byte_sel = '0;
      endcase
      out_in.status      = s1_ff.status;
      out_in.out_byte    = byte_sel;
      out_in.section     = s1_ff.section;
      out_in.last        = s1_ff.last;
      out_in.name_length = s1_ff.name_length;
      out_in.read_length = s1_ff.read_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NAME;
         skipped_ff    <= '0;
         flag_ff       <= '0;
         digit_seen_ff <= 1'b0;
         name_count_ff <= '0;
         base_count_ff <= '0;
         qual_count_ff <= '0;
         pending_ff    <= 1'b0;
         drain_pos_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         skipped_ff    <= skipped_in;
         flag_ff       <= flag_in;
         digit_seen_ff <= digit_seen_in;
         name_count_ff <= name_count_in;
         base_count_ff <= base_count_in;
         qual_count_ff <= qual_count_in;
         pending_ff    <= pending_in;
         drain_pos_ff  <= drain_pos_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= meta_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   samrx_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name_ram (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (name_count_ff[NAME_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (name_re),
      .rd_addr (name_raddr),
      .rd_data (name_rdata)
   );

   samrx_ram #(.WIDTH(8), .DEPTH(MAX_READ)) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (base_count_ff[READ_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (base_re),
      .rd_addr (base_raddr),
      .rd_data (base_rdata)
   );

   samrx_ram #(.WIDTH(8), .DEPTH(MAX_READ)) u_qual_ram (
      .clock   (clock),
      .wr_en   (qual_we),
      .wr_addr (qual_count_ff[READ_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (qual_re),
      .rd_addr (qual_raddr),
      .rd_data (qual_rdata)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_out_byte       = out_ff.out_byte;
   assign rsp_section        = out_ff.section;
   assign rsp_last_of_record = out_ff.last;
   assign rsp_name_length    = out_ff.name_length;
   assign rsp_read_length    = out_ff.read_length;

endmodule

/* rtl/samrx_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module samrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/samrx_checker.sv */
// Port-level checker for the SAM record to read extractor and its bind statement.
module samrx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_mode,
   input logic [7:0]                        req_data_byte,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [3:0]                        rsp_status,
   input logic [7:0]                        rsp_out_byte,
   input logic [1:0]                        rsp_section,
   input logic                              rsp_last_of_record,
   input logic [samrx_pkg::NAME_LEN_W-1:0]  rsp_name_length,
   input logic [samrx_pkg::READ_LEN_W-1:0]  rsp_read_length
);

   import samrx_pkg::*;

   // A request that is not taken stays valid and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_mode) && $stable(req_data_byte))
      else $error("request changed while stalled");

   // A response that is not taken stays valid and keeps its status, byte, section and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_out_byte) && $stable(rsp_section) && $stable(rsp_last_of_record))
      else $error("response changed while stalled");

   // Only a drained byte carries byte, section and end-of-record information.
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BYTE |->
      rsp_out_byte == '0 && rsp_section == '0 && !rsp_last_of_record)
      else $error("byte fields set on a response that is not a drained byte");

   // Only a record-ready response carries the stored lengths.
   a_len_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READY |->
      rsp_name_length == '0 && rsp_read_length == '0)
      else $error("length fields set on a response that is not record ready");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sam_record_to_read_extractor samrx_checker u_samrx_checker (.*);

/* tb/sam_record_to_read_extractor_tb.sv */
// Self-checking testbench for the SAM record extractor: directed and random text with a predictor.
module sam_record_to_read_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import samrx_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int REVERSE_FLAG_BIT = 4;
   localparam int RANDOM_ITEMS = 350;
   localparam int RANDOM_RECORDS = 5;
   localparam int TAIL_ITEMS = 150;
   localparam int SETTLE_CYCLES = 20;
   localparam string SKIP_TABS = "\t\t\t\t\t\t\t";

   typedef enum int {FILL_NAME, FILL_BASE, FILL_QUAL, FILL_ANY} fill_kind_type;
   typedef enum int {LINE_NL, LINE_TAB, LINE_OPEN} line_end_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data;
   } text_item_type;

   typedef struct packed {
      status_type              status;
      logic [7:0]              data;
      sect_type                sect;
      logic                    last;
      logic [NAME_LEN_W-1:0]   nlen;
      logic [READ_LEN_W-1:0]   rlen;
   } extract_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = MODE_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_status;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_section;
   logic rsp_last_of_record;
   logic [NAME_LEN_W-1:0] rsp_name_length;
   logic [READ_LEN_W-1:0] rsp_read_length;

   text_item_type text_feed[$];
   extract_result_type due_responses[$];
   int err_count = 0;
   int checked_count = 0;
   int tally[16];
   int send_gap = 0;
   int stall_left = 0;
   logic quiet = 1'b1;
   logic [31:0] cycle_no = '0;

   phase_type phase_now = PH_NAME;
   logic [2:0] skip_cnt = '0;
   logic [31:0] flag_acc = '0;
   logic flag_has_digit = 1'b0;
   logic [7:0] name_buf [MAX_NAME];
   logic [7:0] seq_buf [MAX_READ];
   logic [7:0] qual_buf [MAX_READ];
   int unsigned name_fill = 0;
   int unsigned seq_len = 0;
   int unsigned qual_fill = 0;
   int unsigned drain_idx = 0;
   logic holding = 1'b0;

   sam_record_to_read_extractor uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_section        (rsp_section),
      .rsp_last_of_record (rsp_last_of_record),
      .rsp_name_length    (rsp_name_length),
      .rsp_read_length    (rsp_read_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic status_type drop_record(phase_type resume, status_type code);
      name_fill = 0;
      seq_len = 0;
      qual_fill = 0;
      drain_idx = 0;
      phase_now = resume;
      return code;
   endfunction

   function automatic extract_result_type predict_extract(logic [1:0] mode, logic [7:0] c);
      extract_result_type r;
      logic [35:0] acc;
      int unsigned total, pos, idx;
      logic rev;
      r = '0;
      case (mode)
         MODE_BYTE: begin
            case (phase_now)
               PH_NAME: begin
                  if (holding) begin
                     r.status = ST_BUSY;
                  end else if (c == CHAR_TAB) begin
                     phase_now = PH_FLAG;
                     flag_acc = '0;
                     flag_has_digit = 1'b0;
                  end else if (c == CHAR_NL) begin
                     if (name_fill != 0) r.status = drop_record(PH_NAME, ST_INCOMPLETE);
                  end else if (name_fill >= MAX_NAME) begin
                     r.status = drop_record(PH_LINE, ST_LONG);
                  end else begin
                     name_buf[name_fill] = c;
                     name_fill++;
                  end
               end
               PH_FLAG: begin
                  if (c == CHAR_NL) begin
                     r.status = drop_record(PH_NAME, ST_INCOMPLETE);
                  end else if (c == CHAR_TAB) begin
                     if (!flag_has_digit) begin
                        r.status = drop_record(PH_LINE, ST_MALFORMED);
                     end else begin
                        phase_now = PH_SKIP;
                        skip_cnt = '0;
                     end
                  end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     acc = {4'h0, flag_acc} * 36'd10 + {28'h0, c - CHAR_ZERO};
                     if (acc > 36'h0_7FFF_FFFF) begin
                        r.status = drop_record(PH_LINE, ST_MALFORMED);
                     end else begin
                        flag_acc = acc[31:0];
                        flag_has_digit = 1'b1;
                     end
                  end else begin
                     r.status = drop_record(PH_LINE, ST_MALFORMED);
                  end
               end
               PH_SKIP: begin
                  if (c == CHAR_NL) begin
                     r.status = drop_record(PH_NAME, ST_INCOMPLETE);
                  end else if (c == CHAR_TAB) begin
                     skip_cnt = skip_cnt + 3'd1;
                     if (skip_cnt >= SKIP_FIELDS) phase_now = PH_SEQ;
                  end
               end
               PH_SEQ: begin
                  if (c == CHAR_NL) begin
                     r.status = drop_record(PH_NAME, ST_INCOMPLETE);
                  end else if (c == CHAR_TAB) begin
                     phase_now = PH_QUAL;
                  end else if (seq_len >= MAX_READ) begin
                     r.status = drop_record(PH_LINE, ST_LONG);
                  end else begin
                     seq_buf[seq_len] = c;
                     seq_len++;
                  end
               end
               PH_QUAL: begin
                  if (c == CHAR_TAB || c == CHAR_NL) begin
                     if (qual_fill != seq_len) begin
                        if (c == CHAR_NL) r.status = drop_record(PH_NAME, ST_MISMATCH);
                        else r.status = drop_record(PH_LINE, ST_MISMATCH);
                     end else begin
                        if (c == CHAR_NL) phase_now = PH_NAME;
                        else phase_now = PH_LINE;
                        holding = 1'b1;
                        drain_idx = 0;
                        r.status = ST_READY;
                        r.nlen = name_fill[NAME_LEN_W-1:0];
                        r.rlen = seq_len[READ_LEN_W-1:0];
                     end
                  end else if (qual_fill >= MAX_READ) begin
                     r.status = drop_record(PH_LINE, ST_LONG);
                  end else begin
                     qual_buf[qual_fill] = c;
                     qual_fill++;
                  end
               end
               default: begin
                  if (c == CHAR_NL) phase_now = PH_NAME;
               end
            endcase
         end
         MODE_DRAIN: begin
            if (!holding) begin
               r.status = ST_EMPTY;
            end else begin
               total = name_fill + 2 * seq_len;
               pos = drain_idx;
               if (pos >= total) begin
                  holding = 1'b0;
                  r.status = drop_record(phase_now, ST_EMPTY);
               end else begin
                  rev = flag_acc[REVERSE_FLAG_BIT];
                  r.status = ST_BYTE;
                  if (pos < name_fill) begin
                     r.data = name_buf[pos];
                     r.sect = SECT_NAME;
                  end else if (pos < name_fill + seq_len) begin
                     idx = pos - name_fill;
                     r.sect = SECT_SEQ;
                     if (rev) begin
                        case (seq_buf[seq_len - 1 - idx])
                           CHAR_A:  r.data = CHAR_T;
                           CHAR_C:  r.data = CHAR_G;
                           CHAR_G:  r.data = CHAR_C;
                           CHAR_T:  r.data = CHAR_A;
                           default: r.data = CHAR_N;
                        endcase
                     end else begin
                        r.data = seq_buf[idx];
                     end
                  end else begin
                     idx = pos - name_fill - seq_len;
                     r.sect = SECT_QUAL;
                     r.data = rev ? qual_buf[seq_len - 1 - idx] : qual_buf[idx];
                  end
                  drain_idx = pos + 1;
                  if (pos + 1 == total) begin
                     r.last = 1'b1;
                     holding = 1'b0;
                     void'(drop_record(phase_now, ST_EMPTY));
                  end
               end
            end
         end
         MODE_END: begin
            if (!holding && phase_now != PH_LINE &&
                (phase_now != PH_NAME || name_fill != 0))
               r.status = drop_record(PH_NAME, ST_INCOMPLETE);
            else
               phase_now = PH_NAME;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_byte(fill_kind_type kind);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (kind == FILL_BASE && $urandom_range(0, 9) != 0) begin
         case ($urandom_range(0, 4))
            0: b = CHAR_A;
            1: b = CHAR_C;
            2: b = CHAR_G;
            3: b = CHAR_T;
            default: b = CHAR_N;
         endcase
      end else if (kind == FILL_QUAL && $urandom_range(0, 9) != 0) begin
         b = 8'($urandom_range(33, 126));
      end
      if (kind != FILL_ANY)
         while (b == CHAR_TAB || b == CHAR_NL) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic bit idling_on();
      return !quiet && cycle_no[9:8] != 2'b00;
   endfunction

   task automatic queue_item(logic [1:0] mode, logic [7:0] data);
      text_item_type t;
      t.mode = mode;
      t.data = data;
      text_feed.push_back(t);
   endtask

   task automatic push_fill(fill_kind_type kind, int n);
      repeat (n) queue_item(MODE_BYTE, pick_byte(kind));
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) queue_item(MODE_BYTE, s[i]);
   endtask

   task automatic push_mode(logic [1:0] mode, int n);
      repeat (n) queue_item(mode, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_record(int nlen, string flag, int slen, int qlen,
                              line_end_type ending);
      push_fill(FILL_NAME, nlen);
      queue_item(MODE_BYTE, CHAR_TAB);
      push_str(flag);
      queue_item(MODE_BYTE, CHAR_TAB);
      repeat (SKIP_FIELDS) begin
         push_fill(FILL_NAME, $urandom_range(0, 2));
         queue_item(MODE_BYTE, CHAR_TAB);
      end
      push_fill(FILL_BASE, slen);
      queue_item(MODE_BYTE, CHAR_TAB);
      push_fill(FILL_QUAL, qlen);
      if (ending != LINE_NL) begin
         queue_item(MODE_BYTE, CHAR_TAB);
         push_fill(FILL_NAME, $urandom_range(0, 6));
      end
      if (ending != LINE_OPEN) queue_item(MODE_BYTE, CHAR_NL);
   endtask

   task automatic flag_mismatch(string msg);
      err_count++;
      if (err_count <= 100) $display("mismatch at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : drive_proc
      logic next_valid;
      text_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            due_responses.push_back(predict_extract(req_mode, req_data_byte));
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (text_feed.size() != 0) begin
               if (idling_on() && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 4);
               end else begin
                  nxt = text_feed.pop_front();
                  req_mode <= nxt.mode;
                  req_data_byte <= nxt.data;
                  next_valid = 1'b1;
               end
            end
            req_valid <= next_valid;
         end
         quiet <= (text_feed.size() < TAIL_ITEMS);
      end
   end

   always @(posedge clock) begin : watch_proc
      extract_result_type want;
      cycle_no <= cycle_no + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               flag_mismatch($sformatf("unexpected transfer with status %0d", rsp_status));
            end else begin
               want = due_responses.pop_front();
               tally[want.status]++;
               if (rsp_status !== want.status || rsp_out_byte !== want.data ||
                   rsp_section !== want.sect || rsp_last_of_record !== want.last ||
                   rsp_name_length !== want.nlen || rsp_read_length !== want.rlen)
                  flag_mismatch($sformatf({"transfer %0d got st=%0d b=%02h sec=%0d ",
                     "last=%0b nl=%0d rl=%0d, want st=%0d b=%02h sec=%0d last=%0b ",
                     "nl=%0d rl=%0d"},
                     checked_count, rsp_status, rsp_out_byte, rsp_section,
                     rsp_last_of_record, rsp_name_length, rsp_read_length,
                     want.status, want.data, want.sect, want.last, want.nlen, want.rlen));
            end
            checked_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus_proc
      int start, drains, pick, nlen, slen, good, mark, cut;
      string flag;

      push_mode(MODE_DRAIN, 1);
      push_mode(MODE_END, 1);
      push_mode(MODE_UNUSED, 1);
      queue_item(MODE_BYTE, CHAR_NL);
      push_record(5, "0", 8, 8, LINE_NL);
      push_mode(MODE_DRAIN, 5 + 16 + 1);
      push_record(3, "2147483647", 6, 6, LINE_TAB);
      push_str("x");
      push_mode(MODE_DRAIN, 3 + 12);
      push_record(0, "16", 0, 0, LINE_NL);
      push_mode(MODE_DRAIN, 1);
      push_record(4, "", 3, 3, LINE_NL);
      push_record(4, "1x", 3, 3, LINE_NL);
      push_record(4, "2147483648", 3, 3, LINE_NL);
      push_record(4, "7", 5, 4, LINE_NL);
      push_record(4, "7", 4, 5, LINE_TAB);
      push_str("ab\n");
      push_str("ab\t12\n");
      push_str("ab\t12\tx\n");
      push_str({"ab\t4\t", SKIP_TABS, "ACG\n"});
      push_str("abc");
      push_mode(MODE_END, 1);
      push_str({"ab\t4\t", SKIP_TABS, "AC\tI"});
      push_mode(MODE_END, 1);
      push_str("q\tz");
      push_mode(MODE_END, 1);
      push_record(3, "16", 4, 4, LINE_OPEN);
      push_mode(MODE_END, 1);
      push_mode(MODE_DRAIN, 3 + 8);
      push_record(MAX_NAME + 1, "0", 2, 2, LINE_NL);

      start = text_feed.size();
      good = 0;
      while (text_feed.size() - start < RANDOM_ITEMS || good < RANDOM_RECORDS) begin
         pick = $urandom_range(0, 99);
         nlen = $urandom_range(0, 6);
         slen = $urandom_range(0, 10);
         case ($urandom_range(0, 3))
            0: flag = $sformatf("%0d", $urandom_range(0, 31));
            1: flag = $sformatf("%0d", $urandom() >> 1);
            default: flag = $sformatf("%0d", $urandom_range(0, 4095));
         endcase
         if ($urandom_range(0, 9) == 0) flag = {"00", flag};
         if (pick < 70) begin
            if ($urandom_range(0, 1) == 0) push_record(nlen, flag, slen, slen, LINE_NL);
            else push_record(nlen, flag, slen, slen, LINE_TAB);
            good++;
            drains = nlen + 2 * slen;
            case ($urandom_range(0, 7))
               0: drains -= $urandom_range(1, 3);
               1: drains += $urandom_range(1, 3);
               default: ;
            endcase
            if (drains < 0) drains = 0;
            push_mode(MODE_DRAIN, drains);
         end else if (pick < 80) begin
            case (pick % 4)
               0: push_record(nlen, {flag, "x"}, slen, slen, LINE_NL);
               1: push_record(nlen, "", slen, slen, LINE_TAB);
               2: push_record(nlen, "9999999999", slen, slen, LINE_NL);
               default: push_record(nlen, flag, slen, slen + $urandom_range(1, 3), LINE_TAB);
            endcase
         end else if (pick < 90) begin
            mark = text_feed.size();
            push_record(nlen, flag, slen, slen, LINE_NL);
            cut = $urandom_range(mark, text_feed.size() - 1);
            while (text_feed.size() > cut) void'(text_feed.pop_back());
            if ($urandom_range(0, 1) == 0) queue_item(MODE_BYTE, CHAR_NL);
            else push_mode(MODE_END, 1);
         end else begin
            repeat ($urandom_range(1, 6))
               queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end
      push_mode(MODE_DRAIN, 60);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (text_feed.size() != 0 || req_valid) @(negedge clock);
      while (due_responses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (due_responses.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
      $display("covered %0d transfers: %0d records ready, %0d bytes drained, %0d empty drains",
               checked_count, tally[ST_READY], tally[ST_BYTE], tally[ST_EMPTY]);
      $display({"error answers: %0d busy, %0d malformed, %0d mismatch, ",
                "%0d too long, %0d incomplete"},
               tally[ST_BUSY], tally[ST_MALFORMED], tally[ST_MISMATCH], tally[ST_LONG],
               tally[ST_INCOMPLETE]);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
